[src/scht_pkg.sv]
package scht_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_BITS    = 15;
  localparam int R2_BITS        = 2 * RADIUS_BITS;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd256;

  // register stages from request to result
  localparam int LATENCY = 7;

  typedef struct packed {
    logic valid;
    logic seg;     // nearest point lies inside the segment
    logic hit_pt;  // endpoint test result when seg is low
  } ctl_t;

endpackage

[src/scht_diff_mul.sv]
module scht_diff_mul #(
  parameter int COORD_BITS = scht_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  input  logic signed [COORD_BITS-1:0]   prev_x_i,
  input  logic signed [COORD_BITS-1:0]   prev_z_i,
  input  logic signed [COORD_BITS-1:0]   cur_x_i,
  input  logic signed [COORD_BITS-1:0]   cur_z_i,
  input  logic signed [COORD_BITS-1:0]   target_x_i,
  input  logic signed [COORD_BITS-1:0]   target_z_i,
  output logic                           valid_o,
  output logic signed [2*COORD_BITS+1:0] dxdx_o,
  output logic signed [2*COORD_BITS+1:0] dzdz_o,
  output logic signed [2*COORD_BITS+1:0] wxdx_o,
  output logic signed [2*COORD_BITS+1:0] wzdz_o,
  output logic signed [2*COORD_BITS+1:0] wxdz_o,
  output logic signed [2*COORD_BITS+1:0] wzdx_o,
  output logic signed [2*COORD_BITS+1:0] wxwx_o,
  output logic signed [2*COORD_BITS+1:0] wzwz_o,
  output logic signed [2*COORD_BITS+1:0] exex_o,
  output logic signed [2*COORD_BITS+1:0] ezez_o
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  logic                v1_r, v2_r;
  logic signed [D-1:0] dx_nxt, dz_nxt, wx_nxt, wz_nxt, ex_nxt, ez_nxt;
  logic signed [D-1:0] dx_r, dz_r, wx_r, wz_r, ex_r, ez_r;
  logic signed [P-1:0] dxdx_r, dzdz_r, wxdx_r, wzdz_r, wxdz_r;
  logic signed [P-1:0] wzdx_r, wxwx_r, wzwz_r, exex_r, ezez_r;

  // stage 1: coordinate differences
  assign dx_nxt = cur_x_i - prev_x_i;
  assign dz_nxt = cur_z_i - prev_z_i;
  assign wx_nxt = target_x_i - prev_x_i;
  assign wz_nxt = target_z_i - prev_z_i;
  assign ex_nxt = target_x_i - cur_x_i;
  assign ez_nxt = target_z_i - cur_z_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dz_r <= dz_nxt;
    wx_r <= wx_nxt;
    wz_r <= wz_nxt;
    ex_r <= ex_nxt;
    ez_r <= ez_nxt;
  end

  // stage 2: all products
  always_ff @(posedge clk) begin
    dxdx_r <= dx_r * dx_r;
    dzdz_r <= dz_r * dz_r;
    wxdx_r <= wx_r * dx_r;
    wzdz_r <= wz_r * dz_r;
    wxdz_r <= wx_r * dz_r;
    wzdx_r <= wz_r * dx_r;
    wxwx_r <= wx_r * wx_r;
    wzwz_r <= wz_r * wz_r;
    exex_r <= ex_r * ex_r;
    ezez_r <= ez_r * ez_r;
  end

  assign valid_o = v2_r;
  assign dxdx_o  = dxdx_r;
  assign dzdz_o  = dzdz_r;
  assign wxdx_o  = wxdx_r;
  assign wzdz_o  = wzdz_r;
  assign wxdz_o  = wxdz_r;
  assign wzdx_o  = wzdx_r;
  assign wxwx_o  = wxwx_r;
  assign wzwz_o  = wzwz_r;
  assign exex_o  = exex_r;
  assign ezez_o  = ezez_r;

endmodule

[src/scht_reduce.sv]
module scht_reduce #(
  parameter int COORD_BITS = scht_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [scht_pkg::R2_BITS-1:0]     r2_i,
  input  logic                             valid_i,
  input  logic signed [2*COORD_BITS+1:0]   dxdx_i,
  input  logic signed [2*COORD_BITS+1:0]   dzdz_i,
  input  logic signed [2*COORD_BITS+1:0]   wxdx_i,
  input  logic signed [2*COORD_BITS+1:0]   wzdz_i,
  input  logic signed [2*COORD_BITS+1:0]   wxdz_i,
  input  logic signed [2*COORD_BITS+1:0]   wzdx_i,
  input  logic signed [2*COORD_BITS+1:0]   wxwx_i,
  input  logic signed [2*COORD_BITS+1:0]   wzwz_i,
  input  logic signed [2*COORD_BITS+1:0]   exex_i,
  input  logic signed [2*COORD_BITS+1:0]   ezez_i,
  output scht_pkg::ctl_t                   ctl_o,
  output logic [2*COORD_BITS+1:0]          mag_o,
  output logic [2*COORD_BITS+1:0]          len_o
);

  localparam int M  = 2 * COORD_BITS + 2;
  localparam int S  = M + 1;
  localparam int QW = M + scht_pkg::R2_BITS;

  logic                v3_r;
  logic signed [S-1:0] len_r, dot_r, cross_r, pw_r, pe_r;
  logic                len_zero, dot_le0, dot_ge_len, pw_in, pe_in;
  scht_pkg::ctl_t      ctl_nxt, ctl_r;
  logic [M-1:0]        mag_nxt, mag_r, len4_r;

  // stage 3: dot products, squared lengths and cross product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= dxdx_i + dzdz_i;
    dot_r   <= wxdx_i + wzdz_i;
    cross_r <= wxdz_i - wzdx_i;
    pw_r    <= wxwx_i + wzwz_i;
    pe_r    <= exex_i + ezez_i;
  end

  // stage 4: region select, endpoint tests, cross magnitude
  always_comb begin
    len_zero   = (len_r == '0);
    dot_le0    = dot_r[S-1] || (dot_r == '0);
    dot_ge_len = (dot_r >= len_r);
    pw_in      = (QW'(pw_r[M-1:0]) <= QW'(r2_i));
    pe_in      = (QW'(pe_r[M-1:0]) <= QW'(r2_i));
    mag_nxt    = cross_r[S-1] ? M'(-cross_r) : M'(cross_r);
    ctl_nxt.valid = v3_r;
    priority if (len_zero || dot_le0) begin
      ctl_nxt.seg    = 1'b0;
      ctl_nxt.hit_pt = pw_in;
    end else if (dot_ge_len) begin
      ctl_nxt.seg    = 1'b0;
      ctl_nxt.hit_pt = pe_in;
    end else begin
      ctl_nxt.seg    = 1'b1;
      ctl_nxt.hit_pt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    len4_r <= len_r[M-1:0];
  end

  assign ctl_o = ctl_r;
  assign mag_o = mag_r;
  assign len_o = len4_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.valid && ctl_o.seg |-> len_o != '0)
    else $error("reduce: segment case with zero length");

endmodule

[src/scht_cross_cmp.sv]
module scht_cross_cmp #(
  parameter int COORD_BITS = scht_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [scht_pkg::R2_BITS-1:0] r2_i,
  input  scht_pkg::ctl_t               ctl_i,
  input  logic [2*COORD_BITS+1:0]      mag_i,
  input  logic [2*COORD_BITS+1:0]      len_i,
  output logic                         valid_o,
  output logic                         hit_o
);

  localparam int H  = COORD_BITS + 1;
  localparam int M  = 2 * H;
  localparam int RB = scht_pkg::R2_BITS;
  localparam int KW = 2 * M + RB;

  scht_pkg::ctl_t   ctl5_r, ctl6_r;
  logic [2*H-1:0]   hh_r, hl_r, ll_r;
  logic [H+RB-1:0]  lh_r, lo_r;
  logic [KW-1:0]    lhs_r, rhs_r;
  logic             v7_r, hit7_r;

  // stage 5: split products, halves of cross magnitude and length
  always_ff @(posedge clk) begin
    hh_r <= mag_i[M-1:H] * mag_i[M-1:H];
    hl_r <= mag_i[M-1:H] * mag_i[H-1:0];
    ll_r <= mag_i[H-1:0] * mag_i[H-1:0];
    lh_r <= len_i[M-1:H] * r2_i;
    lo_r <= len_i[H-1:0] * r2_i;
  end

  // stage 6: recombine cross^2 and r^2 * L
  always_ff @(posedge clk) begin
    lhs_r <= (KW'(hh_r) << (2 * H)) + (KW'(hl_r) << (H + 1)) + KW'(ll_r);
    rhs_r <= (KW'(lh_r) << H) + KW'(lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
      ctl6_r <= '0;
      v7_r   <= 1'b0;
    end else begin
      ctl5_r <= ctl_i;
      ctl6_r <= ctl5_r;
      v7_r   <= ctl6_r.valid;
    end
  end

  // stage 7: final compare
  always_ff @(posedge clk) begin
    hit7_r <= ctl6_r.seg ? (lhs_r <= rhs_r) : ctl6_r.hit_pt;
  end

  assign valid_o = v7_r;
  assign hit_o   = hit7_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.valid && !ctl_i.seg |-> ##3 (valid_o && hit_o == $past(ctl_i.hit_pt, 3)))
    else $error("cross_cmp: endpoint result altered");

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.valid && ctl_i.seg && mag_i == '0 |-> ##3 hit_o)
    else $error("cross_cmp: pass through centre missed");

endmodule

[src/segment_circle_hit_test.sv]
// A request taken at a clock edge gives its result strobe once it has passed all pipeline stages.
// Throughput: one request per cycle while busy is low; seven pipeline stages, multipliers registered.
// busy is high only in reset and the cycle after; the result receiver cannot stall.
// Reset (rst_n low, synchronous) clears all stage valids and sets hit_radius to 256.
module segment_circle_hit_test #(
  parameter int COORD_BITS = scht_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        in_prev_x,
  input  logic signed [COORD_BITS-1:0]        in_prev_z,
  input  logic signed [COORD_BITS-1:0]        in_cur_x,
  input  logic signed [COORD_BITS-1:0]        in_cur_z,
  input  logic signed [COORD_BITS-1:0]        in_target_x,
  input  logic signed [COORD_BITS-1:0]        in_target_z,
  output logic                                out_valid,
  output logic                                out_hit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scht_pkg::RADIUS_BITS-1:0]    cfg_hit_radius
);

  localparam int P = 2 * COORD_BITS + 2;

  logic                             busy_r;
  logic                             in_accept;
  logic [scht_pkg::RADIUS_BITS-1:0] radius_r;
  logic [scht_pkg::R2_BITS-1:0]     r2_r;
  logic                             v2;
  logic signed [P-1:0]              dxdx, dzdz, wxdx, wzdz, wxdz, wzdx, wxwx, wzwz, exex, ezez;
  scht_pkg::ctl_t                   ctl4;
  logic [P-1:0]                     mag4, len4;

  assign in_accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      radius_r <= scht_pkg::RADIUS_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_hit_radius;
      end
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
  end

  scht_diff_mul #(.COORD_BITS(COORD_BITS)) u_diff_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (in_accept),
    .prev_x_i   (in_prev_x),
    .prev_z_i   (in_prev_z),
    .cur_x_i    (in_cur_x),
    .cur_z_i    (in_cur_z),
    .target_x_i (in_target_x),
    .target_z_i (in_target_z),
    .valid_o    (v2),
    .dxdx_o     (dxdx),
    .dzdz_o     (dzdz),
    .wxdx_o     (wxdx),
    .wzdz_o     (wzdz),
    .wxdz_o     (wxdz),
    .wzdx_o     (wzdx),
    .wxwx_o     (wxwx),
    .wzwz_o     (wzwz),
    .exex_o     (exex),
    .ezez_o     (ezez)
  );

  scht_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .r2_i    (r2_r),
    .valid_i (v2),
    .dxdx_i  (dxdx),
    .dzdz_i  (dzdz),
    .wxdx_i  (wxdx),
    .wzdz_i  (wzdz),
    .wxdz_i  (wxdz),
    .wzdx_i  (wzdx),
    .wxwx_i  (wxwx),
    .wzwz_i  (wzwz),
    .exex_i  (exex),
    .ezez_i  (ezez),
    .ctl_o   (ctl4),
    .mag_o   (mag4),
    .len_o   (len4)
  );

  scht_cross_cmp #(.COORD_BITS(COORD_BITS)) u_cross_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .r2_i    (r2_r),
    .ctl_i   (ctl4),
    .mag_i   (mag4),
    .len_i   (len4),
    .valid_o (out_valid),
    .hit_o   (out_hit)
  );

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##(scht_pkg::LATENCY) out_valid)
    else $error("top: request produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, scht_pkg::LATENCY))
    else $error("top: result without request");

  assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> !busy_r)
    else $error("top: busy rose outside reset");

endmodule
